// ===== hw/rtl/midiclk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midiclk_pkg
// Shared widths, MIDI codes, state and control types of the MIDI clock
// generator.
// ----------------------------------------------------------------------------
package midiclk_pkg;

    // Field and state widths
    localparam int ACC_W      = 36;
    localparam int FRAC_DEF   = 16;
    localparam int SPS_W      = 18;
    localparam int TEMPO_W    = 13;
    localparam int BLK_W      = 12;
    localparam int POS_W      = 24;
    localparam int SPP_W      = 14;
    localparam int LEN_W      = 2;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Sample rate times 40 gives samples per clock times tempo in 1/16 BPM
    localparam int SPS_SCALE  = 40;
    localparam int PROD_W     = SPS_W + 6;

    localparam logic [CNT_W-1:0]   MAX_RESULTS = 6'd33;
    localparam logic [SPS_W-1:0]   SPS_RESET   = 18'd48000;
    localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 13'd16;
    localparam logic [SPP_W-1:0]   SPP_MAX     = 14'd16383;
    localparam logic [SPP_W-1:0]   SPP_START_LIMIT = 14'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPP_EN    = 2'd2;

    // MIDI status bytes and data
    localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
    localparam logic [7:0] MIDI_SPP      = 8'hF2;
    localparam logic [7:0] MIDI_START    = 8'hFA;
    localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
    localparam logic [7:0] MIDI_STOP     = 8'hFC;
    localparam logic [7:0] MIDI_CTRL     = 8'hB0;
    localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
    localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
    localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ACC,
        S_SPP,
        S_START,
        S_STOP,
        S_ASO,
        S_CLK
    } midiclk_state_t;

    typedef enum logic [2:0] {
        MSG_SPP,
        MSG_START,
        MSG_STOP,
        MSG_ASO,
        MSG_CLOCK
    } midiclk_msg_t;

    typedef struct packed {
        logic         accept;
        logic         acc_update;
        logic         emit;
        midiclk_msg_t kind;
        logic         last;
    } midiclk_cmd_t;

    typedef struct packed {
        logic run;
        logic rise;
        logic fall;
        logic transport_en;
        logic spp_en;
        logic div_done;
        logic has_clk;
        logic next_clk;
        logic out_free;
    } midiclk_sts_t;

endpackage

// ===== hw/rtl/midiclk_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midiclk_if
// Valid/ready channels: audio block items in, MIDI messages out.
// ----------------------------------------------------------------------------
interface midiclk_in_if import midiclk_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               run_enable;
    logic [TEMPO_W-1:0] tempo_bpm_x16;
    logic [BLK_W-1:0]   block_samples;
    logic [POS_W-1:0]   beat_position_x256;

    modport source (
        output valid, run_enable, tempo_bpm_x16, block_samples, beat_position_x256,
        input  ready
    );
    modport sink (
        input  valid, run_enable, tempo_bpm_x16, block_samples, beat_position_x256,
        output ready
    );
endinterface

interface midiclk_out_if import midiclk_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] msg_len;
    logic [7:0]       msg_byte0;
    logic [6:0]       msg_byte1;
    logic [6:0]       msg_byte2;
    logic             last_message;

    modport source (
        output valid, msg_len, msg_byte0, msg_byte1, msg_byte2, last_message,
        input  ready
    );
    modport sink (
        input  valid, msg_len, msg_byte0, msg_byte1, msg_byte2, last_message,
        output ready
    );
endinterface

// ===== hw/rtl/midiclk_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midiclk_div
// Restoring divider, one quotient bit per cycle: clock interval in Q.FRAC
// samples = (sample rate * 40) << FRAC / tempo.
// ----------------------------------------------------------------------------
module midiclk_div import midiclk_pkg::*; #(
    parameter int FRAC = FRAC_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [SPS_W-1:0]          sps,
    input  logic [TEMPO_W-1:0]        tempo,
    output logic                      busy,
    output logic [PROD_W+FRAC-1:0]    quotient
);

    localparam int DIV_W  = PROD_W + FRAC;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]   dvd_reg, dvd_next;
    logic [TEMPO_W-1:0] rem_reg, rem_next;
    logic [TEMPO_W-1:0] den_reg, den_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;

    logic [SPS_W-1:0]   sps_eff;
    logic [PROD_W-1:0]  prod;
    logic [TEMPO_W-1:0] tempo_eff;
    logic [TEMPO_W:0]   trial;
    logic [TEMPO_W+1:0] diff;

    // Operand conditioning and one restoring step
    always_comb
    begin
        sps_eff   = (sps == '0) ? SPS_W'(1) : sps;
        prod      = PROD_W'(sps_eff) * PROD_W'(SPS_SCALE);
        tempo_eff = (tempo < TEMPO_MIN) ? TEMPO_MIN : tempo;
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        diff      = {1'b0, trial} - {2'b00, den_reg};

        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dvd_next  = {prod, {FRAC{1'b0}}};
            rem_next  = '0;
            den_next  = tempo_eff;
            cnt_next  = DCNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (diff[TEMPO_W+1])
            begin
                rem_next = trial[TEMPO_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[TEMPO_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
            end
            cnt_next  = cnt_reg - DCNT_W'(1);
            busy_next = (cnt_reg != DCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

// ===== hw/rtl/midiclk_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midiclk_dp
// Datapath: configuration, item capture, run edge detect, phase accumulator,
// interval divider and the output message register.
// ----------------------------------------------------------------------------
module midiclk_dp import midiclk_pkg::*; #(
    parameter int FRAC = FRAC_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  midiclk_cmd_t          cmd,
    output midiclk_sts_t          sts,
    // item payload
    input  logic                  run_enable,
    input  logic [TEMPO_W-1:0]    tempo_bpm_x16,
    input  logic [BLK_W-1:0]      block_samples,
    input  logic [POS_W-1:0]      beat_position_x256,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // message output
    output logic                  msg_valid,
    input  logic                  msg_ready,
    output logic [LEN_W-1:0]      msg_len,
    output logic [7:0]            msg_byte0,
    output logic [6:0]            msg_byte1,
    output logic [6:0]            msg_byte2,
    output logic                  last_message
);

    localparam int DIV_W = PROD_W + FRAC;
    localparam int CMP_W = (DIV_W > ACC_W) ? DIV_W : ACC_W;

    logic [SPS_W-1:0] sps_reg;
    logic             te_reg;
    logic             spe_reg;
    logic             prev_run_reg;
    logic             run_reg;
    logic             rise_reg;
    logic             fall_reg;
    logic [BLK_W-1:0] blk_reg;
    logic [SPP_W-1:0] spp_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;

    logic             out_valid_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic [7:0]       out_b0_reg;
    logic [6:0]       out_b1_reg;
    logic [6:0]       out_b2_reg;
    logic             out_last_reg;

    logic             div_busy;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] interval;
    logic [CMP_W-1:0] acc_ext;
    logic [CMP_W-1:0] int_ext;
    logic [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0] acc_add;
    logic [SPP_W-1:0] spp_in;

    midiclk_div #(
        .FRAC (FRAC)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accept && run_enable),
        .sps      (sps_reg),
        .tempo    (tempo_bpm_x16),
        .busy     (div_busy),
        .quotient (quot)
    );

    // Interval, saturating add and comparisons
    always_comb
    begin
        interval = (quot == '0) ? DIV_W'(1) : quot;
        acc_ext  = CMP_W'(acc_reg);
        int_ext  = CMP_W'(interval);
        acc_sum  = (ACC_W+1)'(acc_reg) + ((ACC_W+1)'(blk_reg) << FRAC);
        acc_add  = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        spp_in   = (beat_position_x256[POS_W-1:POS_W-4] != '0) ? SPP_MAX
                 : beat_position_x256[POS_W-5:6];

        acc_next = acc_reg;
        if (cmd.acc_update)
        begin
            if (fall_reg)
                acc_next = '0;
            else if (run_reg)
                acc_next = acc_add;
        end
        else if (cmd.emit && cmd.kind == MSG_CLOCK)
        begin
            acc_next = acc_reg - interval[ACC_W-1:0];
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.run          = run_reg;
        sts.rise         = rise_reg;
        sts.fall         = fall_reg;
        sts.transport_en = te_reg;
        sts.spp_en       = spe_reg;
        sts.div_done     = !div_busy;
        sts.has_clk      = acc_ext >= int_ext;
        sts.next_clk     = {1'b0, acc_ext} >= {int_ext, 1'b0};
        sts.out_free     = !out_valid_reg || msg_ready;
    end

    // Control state: configuration, run history, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sps_reg       <= SPS_RESET;
            te_reg        <= 1'b1;
            spe_reg       <= 1'b1;
            prev_run_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SPS:       sps_reg <= cfg_data[SPS_W-1:0];
                    CFG_TRANSPORT: te_reg  <= cfg_data[0];
                    CFG_SPP_EN:    spe_reg <= cfg_data[0];
                    default:       ;
                endcase
            end
            if (cmd.accept)
                prev_run_reg <= run_enable;
            acc_reg <= acc_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (msg_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            run_reg  <= run_enable;
            rise_reg <= run_enable && !prev_run_reg;
            fall_reg <= !run_enable && prev_run_reg;
            blk_reg  <= block_samples;
            spp_reg  <= spp_in;
        end
    end

    // Message build
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_last_reg <= cmd.last;
            out_b1_reg   <= '0;
            out_b2_reg   <= '0;
            out_len_reg  <= LEN_ONE;
            unique case (cmd.kind)
                MSG_SPP:
                begin
                    out_len_reg <= LEN_THREE;
                    out_b0_reg  <= MIDI_SPP;
                    out_b1_reg  <= spp_reg[6:0];
                    out_b2_reg  <= spp_reg[13:7];
                end
                MSG_START:
                    out_b0_reg <= (spp_reg < SPP_START_LIMIT) ? MIDI_START : MIDI_CONTINUE;
                MSG_STOP:
                    out_b0_reg <= MIDI_STOP;
                MSG_ASO:
                begin
                    out_len_reg <= LEN_THREE;
                    out_b0_reg  <= MIDI_CTRL;
                    out_b1_reg  <= CC_ALL_SOUND_OFF;
                end
                default:
                    out_b0_reg <= MIDI_CLOCK;
            endcase
        end
    end

    assign msg_valid    = out_valid_reg;
    assign msg_len      = out_len_reg;
    assign msg_byte0    = out_b0_reg;
    assign msg_byte1    = out_b1_reg;
    assign msg_byte2    = out_b2_reg;
    assign last_message = out_last_reg;

endmodule

// ===== hw/rtl/midiclk_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midiclk_ctrl
// Controller: accepts an item, waits for the interval divide if it runs,
// updates the accumulator and sequences the messages with the last-message flag.
// ----------------------------------------------------------------------------
module midiclk_ctrl import midiclk_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         item_run,
    output logic         item_ready,
    input  midiclk_sts_t sts,
    output midiclk_cmd_t cmd
);

    midiclk_state_t   state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        room       = n_reg < MAX_RESULTS;
        state_next = state_reg;
        n_next     = n_reg;
        item_ready = 1'b0;
        cmd        = '0;
        cmd.kind   = MSG_CLOCK;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    n_next     = '0;
                    state_next = item_run ? S_DIV : S_ACC;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_update = 1'b1;
                if (sts.rise && sts.transport_en)
                    state_next = sts.spp_en ? S_SPP : S_START;
                else if (sts.fall && sts.transport_en)
                    state_next = S_STOP;
                else if (sts.run)
                    state_next = S_CLK;
                else
                    state_next = S_IDLE;
            end
            S_SPP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = MSG_SPP;
                    n_next     = n_reg + CNT_W'(1);
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = MSG_START;
                    cmd.last   = !(sts.run && sts.has_clk);
                    n_next     = n_reg + CNT_W'(1);
                    state_next = cmd.last ? S_IDLE : S_CLK;
                end
            end
            S_STOP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = MSG_STOP;
                    n_next     = n_reg + CNT_W'(1);
                    state_next = S_ASO;
                end
            end
            S_ASO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = MSG_ASO;
                    cmd.last   = 1'b1;
                    n_next     = n_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_CLK:
            begin
                // Clock loop: stops when the accumulator runs short or the
                // per-block message budget is used up
                if (!(sts.has_clk && room))
                    state_next = S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = MSG_CLOCK;
                    cmd.last   = (n_reg == MAX_RESULTS - CNT_W'(1)) || !sts.next_clk;
                    n_next     = n_reg + CNT_W'(1);
                    state_next = cmd.last ? S_IDLE : S_CLK;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/midi_clock_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_clock_generator
// MIDI timing clock generator, 24 pulses per quarter note, driven by audio
// blocks.
// ----------------------------------------------------------------------------
// Usage:
//  - item: one transaction per audio block (run flag, tempo, sample count,
//    beat position). msg: one transaction per MIDI message, last_message set
//    on the final message of a block; a block may produce no message at all.
//  - cfg_we/cfg_index/cfg_data write sample rate, transport enable and song
//    position enable; write only while no block is in progress.
//  - Timing: a running block waits on the serial interval divider, then on the
//    accumulator update; its messages then follow at one message per cycle while
//    the receiver does not stall, up to 33. A stopped block takes the accept and
//    the accumulator step, plus its Stop messages.
//  - One block is processed at a time; the next is taken once the last
//    message of the current one sits in the output register.
//  - When the receiver stalls, the output register holds its message and the
//    sequencer waits; nothing is dropped.
//  - Reset: stopped, accumulator cleared, 48000 samples/s, transport and song
//    position messages enabled.
// ----------------------------------------------------------------------------
module midi_clock_generator import midiclk_pkg::*; #(
    parameter int ACC_FRAC_BITS = FRAC_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    midiclk_in_if.sink            item,
    midiclk_out_if.source         msg,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    midiclk_cmd_t cmd;
    midiclk_sts_t sts;
    logic         item_ready;

    assign item.ready = item_ready;

    midiclk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_run   (item.run_enable),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    midiclk_dp #(
        .FRAC (ACC_FRAC_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .run_enable         (item.run_enable),
        .tempo_bpm_x16      (item.tempo_bpm_x16),
        .block_samples      (item.block_samples),
        .beat_position_x256 (item.beat_position_x256),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .msg_valid          (msg.valid),
        .msg_ready          (msg.ready),
        .msg_len            (msg.msg_len),
        .msg_byte0          (msg.msg_byte0),
        .msg_byte1          (msg.msg_byte1),
        .msg_byte2          (msg.msg_byte2),
        .last_message       (msg.last_message)
    );

endmodule

// ===== tb/midiclk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midiclk_checker
// Watches the block channel, the message channel and the register port of the
// MIDI clock generator. It keeps its own copy of the run flag, the phase
// accumulator and the registers, works out the MIDI messages each accepted
// audio block should cause, and compares every accepted message, field by
// field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module midiclk_checker import midiclk_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    midiclk_in_if                 item,
    midiclk_out_if                msg,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    blocks_seen,
    output int                    msgs_seen
);

    localparam int          MAX_REPORTS = 40;
    localparam logic [63:0] ACC_LIMIT   = (64'd1 << ACC_W) - 64'd1;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [7:0]       status;
        logic [6:0]       data1;
        logic [6:0]       data2;
        logic             last;
    } midi_msg_t;

    midi_msg_t        expected_msgs[$];

    // Shadow of the block state and registers
    logic             last_run;
    logic [ACC_W-1:0] phase_acc;
    logic [SPS_W-1:0] sps_copy;
    logic             transport_on;
    logic             spp_on;

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        fail_count++;
        // keep the log short when a whole run goes wrong
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, exp_val,
                     got_val);
    endtask

    function automatic midi_msg_t make_msg(input logic [LEN_W-1:0] len, input logic [7:0] status,
                                           input logic [6:0] data1, input logic [6:0] data2);
        midi_msg_t m;
        m.len    = len;
        m.status = status;
        m.data1  = data1;
        m.data2  = data2;
        m.last   = 1'b0;
        return m;
    endfunction

    // Messages caused by one audio block; updates the shadow state
    task automatic predict_block(input logic run, input logic [TEMPO_W-1:0] tempo,
                                 input logic [BLK_W-1:0] samples,
                                 input logic [POS_W-1:0] pos);
        midi_msg_t        batch[$];
        logic [17:0]      spp_raw;
        logic [SPP_W-1:0] spp;
        logic [63:0]      rate;
        logic [63:0]      tempo_eff;
        logic [63:0]      interval;
        logic [63:0]      acc;
        spp_raw = pos[POS_W-1:6];
        spp     = (spp_raw > 18'(SPP_MAX)) ? SPP_MAX : spp_raw[SPP_W-1:0];
        if (run && !last_run) begin
            if (transport_on) begin
                if (spp_on)
                    batch.insert(batch.size(),
                                 make_msg(LEN_THREE, MIDI_SPP, spp[6:0], spp[13:7]));
                batch.insert(batch.size(),
                             make_msg(LEN_ONE,
                                      (spp < SPP_START_LIMIT) ? MIDI_START : MIDI_CONTINUE,
                                      7'd0, 7'd0));
            end
        end
        else if (!run && last_run) begin
            if (transport_on) begin
                batch.insert(batch.size(), make_msg(LEN_ONE, MIDI_STOP, 7'd0, 7'd0));
                batch.insert(batch.size(),
                             make_msg(LEN_THREE, MIDI_CTRL, CC_ALL_SOUND_OFF, 7'd0));
            end
            phase_acc = '0;
        end
        last_run = run;

        if (run) begin
            rate      = (sps_copy == '0) ? 64'd1 : 64'(sps_copy);
            tempo_eff = (tempo < TEMPO_MIN) ? 64'(TEMPO_MIN) : 64'(tempo);
            interval  = ((rate * 64'(SPS_SCALE)) << FRAC_DEF) / tempo_eff;
            if (interval == 64'd0)
                interval = 64'd1;
            acc = 64'(phase_acc) + (64'(samples) << FRAC_DEF);
            if (acc > ACC_LIMIT)
                acc = ACC_LIMIT;
            // clocks beyond the per-block cap stay in the accumulator
            while (batch.size() < int'(MAX_RESULTS) && acc >= interval) begin
                batch.insert(batch.size(), make_msg(LEN_ONE, MIDI_CLOCK, 7'd0, 7'd0));
                acc = acc - interval;
            end
            phase_acc = acc[ACC_W-1:0];
        end

        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            expected_msgs.insert(expected_msgs.size(), batch[i]);
    endtask

    // Compare one accepted message against the oldest outstanding one
    task automatic check_msg();
        midi_msg_t want;
        msgs_seen++;
        if (expected_msgs.size() == 0) begin
            report_mismatch("unexpected message, status", 0, int'(msg.msg_byte0));
        end
        else begin
            want = expected_msgs.pop_front();
            if (msg.msg_len !== want.len)
                report_mismatch("msg_len", int'(want.len), int'(msg.msg_len));
            if (msg.msg_byte0 !== want.status)
                report_mismatch("msg_byte0", int'(want.status), int'(msg.msg_byte0));
            if (msg.msg_byte1 !== want.data1)
                report_mismatch("msg_byte1", int'(want.data1), int'(msg.msg_byte1));
            if (msg.msg_byte2 !== want.data2)
                report_mismatch("msg_byte2", int'(want.data2), int'(msg.msg_byte2));
            if (msg.last_message !== want.last)
                report_mismatch("last_message", int'(want.last), int'(msg.last_message));
        end
    endtask

    // Register writes, message checks, block predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_msgs.delete();
            last_run     = 1'b0;
            phase_acc    = '0;
            sps_copy     = SPS_RESET;
            transport_on = 1'b1;
            spp_on       = 1'b1;
            fail_count   = 0;
            pending      = 0;
            blocks_seen  = 0;
            msgs_seen    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPS:       sps_copy     = cfg_data[SPS_W-1:0];
                    CFG_TRANSPORT: transport_on = cfg_data[0];
                    CFG_SPP_EN:    spp_on       = cfg_data[0];
                    default:       ; // no such register
                endcase
            end
            if (msg.valid === 1'b1 && msg.ready === 1'b1)
                check_msg();
            if (item.valid === 1'b1 && item.ready === 1'b1)
            begin
                blocks_seen++;
                predict_block(item.run_enable, item.tempo_bpm_x16, item.block_samples,
                              item.beat_position_x256);
            end
            pending = expected_msgs.size();
        end
    end

endmodule

// ===== tb/midi_clock_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_clock_generator_tb
// Stimulus and verdict for the MIDI clock generator. A directed set covers
// run flag edges, start and continue limits, song position saturation, slow
// tempo and the transport switches; a run at the lowest sample rate drives
// the per-block clock cap with a growing backlog; random audio blocks follow
// under several register settings. Both channels idle at random; the checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module midi_clock_generator_tb;
    import midiclk_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int QUIET_CYCLES   = 120;
    localparam int SAT_BLOCKS     = 50;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_BLOCKS   = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    fail_count;
    int                    pending;
    int                    blocks_seen;
    int                    msgs_seen;
    int                    idle_cycles;
    int                    settings_used;
    logic                  steady;
    logic                  cur_run;

    midiclk_in_if  item_ch ();
    midiclk_out_if msg_ch ();

    midi_clock_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .msg       (msg_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    midiclk_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .msg         (msg_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .blocks_seen (blocks_seen),
        .msgs_seen   (msgs_seen)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Watchdog on cycles with no block taken and no outstanding message taken
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) ||
            (msg_ch.valid && msg_ch.ready && pending != 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Message receiver with random stalls
    initial
    begin
        int stall;
        msg_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = gap_len();
            if (stall > 0)
            begin
                @(negedge clk) msg_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) msg_ch.ready <= 1'b1;
            if (!steady)
                repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    // Sender gap after a transaction
    task automatic sender_gap();
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk) item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // One audio block transaction
    task automatic send_block(input logic run, input logic [TEMPO_W-1:0] tempo,
                              input logic [BLK_W-1:0] samples, input logic [POS_W-1:0] pos);
        @(negedge clk);
        item_ch.valid              <= 1'b1;
        item_ch.run_enable         <= run;
        item_ch.tempo_bpm_x16      <= tempo;
        item_ch.block_samples      <= samples;
        item_ch.beat_position_x256 <= pos;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        cur_run = run;
        sender_gap();
    endtask

    // Hold off until every message is in and the block has gone quiet
    task automatic settle();
        @(negedge clk) item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input logic [SPS_W-1:0] rate, input logic transport,
                                  input logic spp);
        settle();
        write_reg(CFG_SPS, CFG_DATA_W'(rate));
        write_reg(CFG_TRANSPORT, CFG_DATA_W'(transport));
        write_reg(CFG_SPP_EN, CFG_DATA_W'(spp));
        settings_used++;
    endtask

    // Mostly plausible playback with occasional run edges, some raw noise
    task automatic random_block();
        logic                run;
        logic [TEMPO_W-1:0]  tempo;
        logic [BLK_W-1:0]    samples;
        logic [POS_W-1:0]    pos;
        if ($urandom_range(0, 9) < 8)
        begin
            run     = ($urandom_range(0, 9) == 0) ? ~cur_run : cur_run;
            tempo   = TEMPO_W'($urandom_range(960, 3200));
            samples = BLK_W'($urandom_range(64, 1024));
            pos     = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 200))
                                                  : POS_W'($urandom());
        end
        else
        begin
            run     = 1'($urandom_range(0, 1));
            tempo   = TEMPO_W'($urandom());
            samples = BLK_W'($urandom());
            pos     = POS_W'($urandom());
        end
        send_block(run, tempo, samples, pos);
    endtask

    // Main sequence
    initial
    begin
        logic [SPS_W-1:0] rate;
        rst_n                      = 1'b0;
        cfg_we                     = 1'b0;
        cfg_index                  = CFG_SPS;
        cfg_data                   = '0;
        item_ch.valid              = 1'b0;
        item_ch.run_enable         = 1'b0;
        item_ch.tempo_bpm_x16      = '0;
        item_ch.block_samples      = '0;
        item_ch.beat_position_x256 = '0;
        idle_cycles                = 0;
        settings_used              = 1;
        steady                     = 1'b0;
        cur_run                    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed blocks under reset settings
        send_block(1'b0, 13'd1920, 12'd512, 24'd0);        // stopped, nothing sent
        send_block(1'b1, 13'd0, 12'd4095, 24'd0);          // start, tempo clamped up
        send_block(1'b1, 13'h1FFF, 12'hFFF, 24'd0);        // fastest tempo, many clocks
        send_block(1'b1, 13'h1FFF, 12'd0, 24'd0);          // empty block
        send_block(1'b0, 13'h1FFF, 12'hFFF, 24'd0);        // stop and all sound off
        send_block(1'b1, 13'd1920, 12'd1024, 24'd127);     // position just below continue
        send_block(1'b0, 13'd1920, 12'd1024, 24'd127);
        send_block(1'b1, 13'd4800, 12'd2048, 24'd128);     // first continue position
        send_block(1'b0, 13'd4800, 12'd2048, 24'd128);
        send_block(1'b1, 13'd1920, 12'd256, 24'hFFFFFF);   // song position saturates
        send_block(1'b0, 13'd1920, 12'd256, 24'hFFFFFF);
        send_block(1'b1, 13'd1920, 12'd256, 24'h0FFFFF);   // top position, unsaturated
        send_block(1'b0, 13'd15, 12'd256, 24'h0AAAAA);

        // Transport off: clocks only, stop still clears the accumulator
        settle();
        write_reg(CFG_TRANSPORT, CFG_DATA_W'(1'b0));
        settings_used++;
        send_block(1'b1, 13'd3200, 12'd1024, 24'd5000);
        send_block(1'b1, 13'd3200, 12'd1024, 24'd5000);
        send_block(1'b0, 13'd3200, 12'd1024, 24'd5000);

        // Transport on, song position off
        settle();
        write_reg(CFG_TRANSPORT, CFG_DATA_W'(1'b1));
        write_reg(CFG_SPP_EN, CFG_DATA_W'(1'b0));
        settings_used++;
        send_block(1'b1, 13'd1920, 12'd512, 24'd64);
        send_block(1'b0, 13'd1920, 12'd512, 24'd64);
        send_block(1'b1, 13'd1920, 12'd512, 24'h123456);
        send_block(1'b0, 13'd1920, 12'd512, 24'h123456);

        // Zero sample rate at top tempo: clock cap on every block while the
        // backlog grows; a write to a missing register is ignored
        apply_settings('0, 1'b1, 1'b1);
        write_reg(CFG_UNUSED, '1);
        send_block(1'b1, 13'h1FFF, 12'hFFF, 24'd0);
        repeat (SAT_BLOCKS) send_block(1'b1, 13'h1FFF, 12'hFFF, 24'd0);
        send_block(1'b0, 13'h1FFF, 12'hFFF, 24'd0);

        // Highest sample rate at the slowest tempo
        apply_settings('1, 1'b1, 1'b1);
        send_block(1'b1, 13'd16, 12'hFFF, 24'd300);
        send_block(1'b1, 13'd0, 12'hFFF, 24'd300);
        send_block(1'b0, 13'd16, 12'hFFF, 24'd300);

        // Random blocks under several settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       rate = 18'd8000;
                1:       rate = 18'd192000;
                2:       rate = 18'd44100;
                3:       rate = SPS_W'($urandom());
                default: rate = 18'd1;
            endcase
            if (ph == 0)
                apply_settings(rate, 1'b1, 1'b1);
            else
                apply_settings(rate, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (ph == 3)
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
            for (int n = 0; n < PHASE_BLOCKS; n++)
            begin
                // a stretch with no idling on either side
                steady = (ph == 2 && n < 20);
                random_block();
                // now and then let every outstanding message drain first
                if ($urandom_range(0, 24) == 0)
                begin
                    @(negedge clk) item_ch.valid <= 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                end
            end
            steady = 1'b0;
        end

        settle();
        $display("Covered %0d audio blocks and %0d MIDI messages under %0d register settings,",
                 blocks_seen, msgs_seen, settings_used);
        $display("including the per-block clock cap and all transport edges.");
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/midiclk_pkg.sv
hw/rtl/midiclk_if.sv
hw/rtl/midiclk_div.sv
hw/rtl/midiclk_dp.sv
hw/rtl/midiclk_ctrl.sv
hw/rtl/midi_clock_generator.sv
tb/midiclk_checker.sv
tb/midi_clock_generator_tb.sv
